[rtl/icavg_pkg.sv]
`timescale 1ns / 1ps

package icavg_pkg;

    // Stream and arithmetic widths
    localparam int SAMPLE_BITS   = 12;
    localparam int CHANNELS      = 5;
    localparam int MAX_AVERAGE   = 256;
    localparam int AVG_BITS      = 9;                    // average_count register
    localparam int AVG_LOG2      = 8;                    // log2(MAX_AVERAGE)
    localparam int SUM_BITS      = SAMPLE_BITS + AVG_LOG2;
    localparam int FRAC_BITS     = 8;                    // Q12.8
    localparam int MEAN_BITS     = 20;
    localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
    localparam int CH_BITS       = 3;                    // channel_count register
    localparam int POS_BITS      = 11;                   // start_position / position
    localparam int PROD_BITS     = CH_BITS + AVG_BITS;

    // Iterative unit step counts
    localparam int MOD_STEPS = POS_BITS;                 // start_position mod channels
    localparam int DIV_STEPS = DIVIDEND_BITS;            // (sum << 8) / average
    localparam int CNT_BITS  = 5;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = POS_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AVERAGE_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_POSITION = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic setup_load;   // start phase computation, reload position
        logic setup_step;   // one remainder step of the phase computation
        logic accept;       // a sample request is taken this cycle
        logic div_step;     // one quotient bit on every channel lane
        logic out_load;     // copy quotients into the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_sample;  // the sample at the port closes the frame
    } status_t;

endpackage

[rtl/icavg_if.sv]
`timescale 1ns / 1ps

// Sample stream channel
interface icavg_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [icavg_pkg::SAMPLE_BITS-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: five channel means
interface icavg_mean_if;
    logic                                 valid;
    logic                                 ready;
    logic [icavg_pkg::MEAN_BITS-1:0]      mean_ch0;
    logic [icavg_pkg::MEAN_BITS-1:0]      mean_ch1;
    logic [icavg_pkg::MEAN_BITS-1:0]      mean_ch2;
    logic [icavg_pkg::MEAN_BITS-1:0]      mean_ch3;
    logic [icavg_pkg::MEAN_BITS-1:0]      mean_ch4;

    modport source (output valid, output mean_ch0, output mean_ch1, output mean_ch2,
                    output mean_ch3, output mean_ch4, input ready);
    modport sink   (input valid, input mean_ch0, input mean_ch1, input mean_ch2,
                    input mean_ch3, input mean_ch4, output ready);
endinterface

[rtl/icavg_datapath.sv]
`timescale 1ns / 1ps

module icavg_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [icavg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [icavg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  icavg_pkg::cmd_t                       cmd,
    output icavg_pkg::status_t                    status,
    input  logic [icavg_pkg::SAMPLE_BITS-1:0]     sample,
    output logic [icavg_pkg::MEAN_BITS-1:0]       mean [icavg_pkg::CHANNELS]
);

    // Configuration registers
    logic [icavg_pkg::CH_BITS-1:0]   channel_count_reg;
    logic [icavg_pkg::AVG_BITS-1:0]  average_count_reg;
    logic [icavg_pkg::POS_BITS-1:0]  start_position_reg;

    // Frame state
    logic [icavg_pkg::SUM_BITS-1:0]  sum_reg [icavg_pkg::CHANNELS];
    logic [icavg_pkg::SUM_BITS-1:0]  sum_next [icavg_pkg::CHANNELS];
    logic [icavg_pkg::POS_BITS-1:0]  samples_reg;
    logic [icavg_pkg::POS_BITS-1:0]  pos_reg;
    logic [icavg_pkg::CH_BITS-1:0]   ch_reg;
    logic [icavg_pkg::POS_BITS-1:0]  total_reg;

    // Phase computation (start_position mod channels)
    logic [icavg_pkg::CH_BITS-1:0]   phase_reg;
    logic [icavg_pkg::CH_BITS-1:0]   phase_next;
    logic [icavg_pkg::POS_BITS-1:0]  mod_shift_reg;
    logic [icavg_pkg::CH_BITS:0]     mod_trial;

    // Divider lanes
    logic [icavg_pkg::AVG_BITS-1:0]       rem_reg [icavg_pkg::CHANNELS];
    logic [icavg_pkg::DIVIDEND_BITS-1:0]  quo_reg [icavg_pkg::CHANNELS];

    logic [icavg_pkg::MEAN_BITS-1:0]      mean_reg [icavg_pkg::CHANNELS];

    logic [icavg_pkg::CH_BITS-1:0]   cc_eff;
    logic [icavg_pkg::AVG_BITS-1:0]  ac_eff;
    logic [icavg_pkg::PROD_BITS-1:0] total_prod;
    logic                            pos_wrap;
    logic [icavg_pkg::POS_BITS-1:0]  pos_eff;
    logic [icavg_pkg::CH_BITS-1:0]   ch_eff;
    logic [icavg_pkg::CH_BITS-1:0]   ch_step;
    logic [icavg_pkg::POS_BITS:0]    seen_plus;
    logic                            frame_end;

    // Effective register values, clamped to their legal ranges
    always_comb
    begin
        if (channel_count_reg == '0)
            cc_eff = icavg_pkg::CH_BITS'(1);
        else if (channel_count_reg > icavg_pkg::CH_BITS'(icavg_pkg::CHANNELS))
            cc_eff = icavg_pkg::CH_BITS'(icavg_pkg::CHANNELS);
        else
            cc_eff = channel_count_reg;

        if (average_count_reg == '0)
            ac_eff = icavg_pkg::AVG_BITS'(1);
        else if (average_count_reg > icavg_pkg::AVG_BITS'(icavg_pkg::MAX_AVERAGE))
            ac_eff = icavg_pkg::AVG_BITS'(icavg_pkg::MAX_AVERAGE);
        else
            ac_eff = average_count_reg;
    end

    assign total_prod = icavg_pkg::PROD_BITS'(cc_eff) * icavg_pkg::PROD_BITS'(ac_eff);

    // Current position and channel, wrapping past the buffer end
    assign pos_wrap = (pos_reg >= total_reg);
    assign pos_eff  = pos_wrap ? '0 : pos_reg;
    assign ch_eff   = pos_wrap ? '0 : ch_reg;
    assign ch_step  = (ch_eff == cc_eff - icavg_pkg::CH_BITS'(1)) ?
                      '0 : ch_eff + icavg_pkg::CH_BITS'(1);

    assign seen_plus   = {1'b0, samples_reg} + (icavg_pkg::POS_BITS + 1)'(1);
    assign frame_end   = (seen_plus >= {1'b0, total_reg});
    assign status.last_sample = frame_end;

    // Sums with the current sample added to its channel
    always_comb
    begin
        for (int k = 0; k < icavg_pkg::CHANNELS; k++)
        begin
            if (ch_eff == icavg_pkg::CH_BITS'(k))
                sum_next[k] = sum_reg[k] + icavg_pkg::SUM_BITS'(sample);
            else
                sum_next[k] = sum_reg[k];
        end
    end

    // Remainder step of the phase computation
    assign mod_trial  = {phase_reg, mod_shift_reg[icavg_pkg::POS_BITS-1]};
    assign phase_next = (mod_trial >= {1'b0, cc_eff}) ?
                        icavg_pkg::CH_BITS'(mod_trial - {1'b0, cc_eff}) :
                        icavg_pkg::CH_BITS'(mod_trial);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg  <= icavg_pkg::CH_BITS'(1);
            average_count_reg  <= icavg_pkg::AVG_BITS'(1);
            start_position_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                icavg_pkg::CFG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[icavg_pkg::CH_BITS-1:0];
                icavg_pkg::CFG_AVERAGE_COUNT:
                    average_count_reg <= cfg_data[icavg_pkg::AVG_BITS-1:0];
                icavg_pkg::CFG_START_POSITION:
                    start_position_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Frame bookkeeping: position, channel, sums, sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < icavg_pkg::CHANNELS; k++)
                sum_reg[k] <= '0;
            samples_reg   <= '0;
            pos_reg       <= '0;
            ch_reg        <= '0;
            total_reg     <= icavg_pkg::POS_BITS'(1);
            phase_reg     <= '0;
            mod_shift_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            for (int k = 0; k < icavg_pkg::CHANNELS; k++)
                sum_reg[k] <= '0;
            samples_reg <= '0;
        end
        else if (cmd.setup_load)
        begin
            pos_reg       <= start_position_reg;
            total_reg     <= total_prod[icavg_pkg::POS_BITS-1:0];
            phase_reg     <= '0;
            mod_shift_reg <= start_position_reg;
        end
        else if (cmd.setup_step)
        begin
            phase_reg     <= phase_next;
            ch_reg        <= phase_next;
            mod_shift_reg <= {mod_shift_reg[icavg_pkg::POS_BITS-2:0], 1'b0};
        end
        else if (cmd.accept)
        begin
            if (frame_end)
            begin
                for (int k = 0; k < icavg_pkg::CHANNELS; k++)
                    sum_reg[k] <= '0;
                samples_reg <= '0;
                pos_reg     <= start_position_reg;
                ch_reg      <= phase_reg;
            end
            else
            begin
                for (int k = 0; k < icavg_pkg::CHANNELS; k++)
                    sum_reg[k] <= sum_next[k];
                samples_reg <= seen_plus[icavg_pkg::POS_BITS-1:0];
                pos_reg     <= pos_eff + icavg_pkg::POS_BITS'(1);
                ch_reg      <= ch_step;
            end
        end
    end

    // Restoring divider, one lane per channel, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < icavg_pkg::CHANNELS; k++)
        begin
            logic [icavg_pkg::AVG_BITS:0] trial;
            trial = {rem_reg[k], quo_reg[k][icavg_pkg::DIVIDEND_BITS-1]};
            if (cmd.accept && frame_end)
            begin
                rem_reg[k] <= '0;
                quo_reg[k] <= {sum_next[k], icavg_pkg::FRAC_BITS'(0)};
            end
            else if (cmd.div_step)
            begin
                if (trial >= {1'b0, ac_eff})
                begin
                    rem_reg[k] <= icavg_pkg::AVG_BITS'(trial - {1'b0, ac_eff});
                    quo_reg[k] <= {quo_reg[k][icavg_pkg::DIVIDEND_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= icavg_pkg::AVG_BITS'(trial);
                    quo_reg[k] <= {quo_reg[k][icavg_pkg::DIVIDEND_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int k = 0; k < icavg_pkg::CHANNELS; k++)
                mean_reg[k] <= quo_reg[k][icavg_pkg::MEAN_BITS-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < icavg_pkg::CHANNELS; k++)
            mean[k] = mean_reg[k];
    end

endmodule

[rtl/icavg_controller.sv]
`timescale 1ns / 1ps

module icavg_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  icavg_pkg::status_t   status,
    output icavg_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_SETUP   = 4'b0001,
        ST_ACCUM   = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_PUBLISH = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [icavg_pkg::CNT_BITS-1:0]  cnt_reg;
    logic [icavg_pkg::CNT_BITS-1:0]  cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_SETUP:
            begin
                if (cnt_reg == '0)
                    cmd.setup_load = 1'b1;
                else
                    cmd.setup_step = 1'b1;
                if (cnt_reg == icavg_pkg::CNT_BITS'(icavg_pkg::MOD_STEPS))
                begin
                    state_next = ST_ACCUM;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + icavg_pkg::CNT_BITS'(1);
            end
            ST_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.last_sample)
                begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == icavg_pkg::CNT_BITS'(icavg_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_PUBLISH;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + icavg_pkg::CNT_BITS'(1);
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
                cnt_next   = '0;
            end
        endcase

        // Any register write restarts the frame
        if (cfg_write_en)
        begin
            state_next = ST_SETUP;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/interleaved_channel_averager_unit.sv]
`timescale 1ns / 1ps
// Samples are taken one per cycle while a frame accumulates. The frame's last sample starts a divide
// (one quotient bit per cycle, five lanes in parallel), and then the result register is loaded,
// which publishes the means, later while the previous means still wait; no samples are taken
// meanwhile. A register write is followed by the computation of the start channel phase. Reset
// is asynchronous, active low, and leaves registers at their defaults with a fresh frame ready
// for samples.

module interleaved_channel_averager_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [icavg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [icavg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    icavg_sample_if.sink                          samples,
    icavg_mean_if.source                          means
);

    icavg_pkg::cmd_t                  cmd;
    icavg_pkg::status_t               status;
    logic [icavg_pkg::MEAN_BITS-1:0]  mean [icavg_pkg::CHANNELS];

    icavg_controller u_controller
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .in_valid     (samples.valid),
        .in_ready     (samples.ready),
        .out_valid    (means.valid),
        .out_ready    (means.ready),
        .status       (status),
        .cmd          (cmd)
    );

    icavg_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .sample       (samples.sample),
        .mean         (mean)
    );

    assign means.mean_ch0 = mean[0];
    assign means.mean_ch1 = mean[1];
    assign means.mean_ch2 = mean[2];
    assign means.mean_ch3 = mean[3];
    assign means.mean_ch4 = mean[4];

endmodule
